FILE: src/chr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the FNV-1a fold for the hash ring lookup unit.
// Used by chr_slot_table and the top level; depends on nothing.
package chr_pkg;

  localparam int NodeSlots = 16;
  localparam int Vnodes    = 16;
  localparam int MaxOut    = 16;
  localparam int SlotW     = $clog2(NodeSlots);
  localparam int RingDepth = NodeSlots * Vnodes;
  localparam int RingAw    = $clog2(RingDepth);
  localparam int SizeW     = RingAw + 1;
  localparam int VnW       = $clog2(Vnodes + 1);
  localparam int RamDw     = 32 + SlotW;
  localparam int WantLim   = (NodeSlots < MaxOut) ? NodeSlots : MaxOut;

  localparam logic [31:0] FnvBasis = 32'h811c9dc5;
  localparam logic [31:0] FnvPrime = 32'h01000193;
  localparam logic [7:0]  CharHash = 8'h23;
  localparam logic [7:0]  CharZero = 8'h30;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_DOWN     = 3'd2;
  localparam logic [2:0] OP_UP       = 3'd3;
  localparam logic [2:0] OP_LOCATE   = 3'd4;
  localparam logic [2:0] OP_REPLICAS = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_RB_SLOT, S_VH_SHARP, S_VH_TENS, S_VH_ONES, S_SRCH, S_SRCH_CMP,
    S_INS_CHK, S_INS_NEW, S_SHIFT_RD, S_SHIFT_WR, S_VADV, S_LK_RD, S_WK_RD, S_WK_EV
  } state_e;

  typedef enum logic [1:0] {K_INS, K_LOC, K_REP} kind_e;

  typedef struct packed {
    logic             we_used;
    logic             we_alive;
    logic             we_hash;
    logic [SlotW-1:0] slot;
    logic             used;
    logic             alive;
    logic [31:0]      hash;
  } slot_wr_t;

  // Only the low 32 bits of the product are kept, so a 32-bit constant
  // multiply is all that is needed.
  function automatic logic [31:0] fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

endpackage

FILE: src/chr_ring_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
// Holds the sorted ring points and their owners; depends on nothing.
module chr_ring_ram #(
  parameter int Aw = 8,
  parameter int Dw = 36
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [Dw-1:0] wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [Dw-1:0] rdata_o
);

  logic [Dw-1:0] mem [2**Aw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/chr_slot_table.sv
`timescale 1ns / 1ps
// Node slot table: used and alive marks plus the id hash of each slot.
// Depends on chr_pkg.
module chr_slot_table import chr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slot_wr_t             wr_i,
  input  logic [SlotW-1:0]     rd_slot_i,
  output logic [31:0]          rd_hash_o,
  output logic [NodeSlots-1:0] used_o,
  output logic [NodeSlots-1:0] alive_o
);

  logic [NodeSlots-1:0] used_q, alive_q;
  logic [31:0]          hash_q [NodeSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      alive_q <= '0;
    end else begin
      if (wr_i.we_used)  used_q[wr_i.slot]  <= wr_i.used;
      if (wr_i.we_alive) alive_q[wr_i.slot] <= wr_i.alive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we_hash) begin
      hash_q[wr_i.slot] <= wr_i.hash;
    end
  end

  assign rd_hash_o = hash_q[rd_slot_i];
  assign used_o    = used_q;
  assign alive_o   = alive_q;

endmodule

FILE: src/consistent_hash_ring_lookup_unit.sv
`timescale 1ns / 1ps
// Top level of the hash ring lookup unit: command FSM, rebuild and search.
// Depends on chr_pkg, chr_slot_table and chr_ring_ram.

// A byte that does not end an item is folded into the running hash while
// the unit stays idle. A last key byte runs a binary search over the ring
// RAM, each probe a read in S_SRCH and a compare in S_SRCH_CMP, then one
// read for a locate, or a read (S_WK_RD) and an evaluation (S_WK_EV) per
// ring point visited for a replicas walk; results come one per cycle at
// most, each shown for exactly one cycle on result_valid_o, and there is no
// way to stall them. Every completed add, every remove, and every mark down
// or mark up of a used slot rebuilds the ring by sorted insertion through
// the single RAM write port: per virtual node the hash steps, a search, and
// a read and a write per entry shifted. busy is high throughout.
module consistent_hash_ring_lookup_unit import chr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       opcode_i,
  input  logic [3:0]       node_slot_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic             start_alive_i,
  input  logic [4:0]       replica_count_i,
  output logic             result_valid_o,
  output logic [3:0]       owner_slot_o,
  output logic             found_o,
  output logic             last_result_o
);

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  logic [31:0]          rh_q, rh_d, vh_q, vh_d;
  logic [SizeW-1:0]     size_q, size_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, j_q, j_d;
  logic [SizeW-1:0]     vis_q, vis_d;
  logic [SlotW:0]       s_q, s_d;
  logic [VnW-1:0]       v_q, v_d;
  logic [RingAw-1:0]    idx_q, idx_d;
  logic [4:0]           want_q, want_d, n_q, n_d;
  logic [NodeSlots-1:0] seen_q, seen_d;
  logic                 pend_v_q, pend_v_d;
  logic [SlotW-1:0]     pend_q, pend_d;
  logic                 ov_q, ov_d, of_q, of_d, ol_q, ol_d;
  logic [SlotW-1:0]     oo_q, oo_d;

  slot_wr_t             swr;
  logic [31:0]          slot_hash;
  logic [NodeSlots-1:0] used, alive;

  logic                 ram_we;
  logic [RingAw-1:0]    ram_waddr, ram_raddr;
  logic [RamDw-1:0]     ram_wdata, ram_rdata;
  logic [31:0]          rd_point;
  logic [SlotW-1:0]     rd_owner;

  logic                 acc, slot_ok, is_key, key_end, empty_res;
  logic [31:0]          fh;
  logic [SizeW-1:0]     mid;
  logic [SlotW-1:0]     cur_slot;
  logic [7:0]           v8, tens, ones;
  logic [17:0]          tprod;
  logic [SizeW-1:0]     idx_inc;
  logic                 walk_go;

  chr_slot_table u_slots (
    .clk_i, .rst_ni, .wr_i(swr), .rd_slot_i(cur_slot),
    .rd_hash_o(slot_hash), .used_o(used), .alive_o(alive)
  );

  chr_ring_ram #(.Aw(RingAw), .Dw(RamDw)) u_ring (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  assign rd_point = ram_rdata[RamDw-1:SlotW];
  assign rd_owner = ram_rdata[SlotW-1:0];
  assign cur_slot = s_q[SlotW-1:0];

  assign busy      = (state_q != S_IDLE);
  assign acc       = start && !busy;
  assign slot_ok   = ({1'b0, node_slot_i} < (SlotW+1)'(NodeSlots));
  assign fh        = fold(rh_q, data_byte_i);
  assign is_key    = (opcode_i == OP_LOCATE) || (opcode_i == OP_REPLICAS);
  assign key_end   = is_key && last_byte_i;
  assign empty_res = (size_q == '0) || ((opcode_i == OP_REPLICAS) && (replica_count_i == '0));
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_inc   = {1'b0, idx_q} + 1'b1;
  assign walk_go   = (vis_q < size_q) && (n_q < want_q);

  // Two decimal digits of the vnode number; the reciprocal holds for every 8-bit value.
  assign v8    = 8'(v_q);
  assign tprod = 18'(v8) * 18'd205;
  assign tens  = 8'(tprod[17:11]);
  assign ones  = v8 - 8'(tens * 8'd10);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (opcode_i)
            OP_ADD:               if (last_byte_i && slot_ok) state_d = S_RB_SLOT;
            OP_REMOVE:            if (slot_ok) state_d = S_RB_SLOT;
            OP_DOWN, OP_UP:       if (slot_ok && used[node_slot_i]) state_d = S_RB_SLOT;
            OP_LOCATE, OP_REPLICAS: if (last_byte_i && !empty_res) state_d = S_SRCH;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_RB_SLOT: begin
        if (s_q == (SlotW+1)'(NodeSlots)) state_d = S_IDLE;
        else if (used[cur_slot] && alive[cur_slot]) state_d = S_VH_SHARP;
      end
      S_VH_SHARP: state_d = (v8 >= 8'd10) ? S_VH_TENS : S_VH_ONES;
      S_VH_TENS:  state_d = S_VH_ONES;
      S_VH_ONES:  state_d = S_SRCH;
      S_SRCH: begin
        if (lo_q < hi_q) state_d = S_SRCH_CMP;
        else begin
          case (kind_q)
            K_INS:   state_d = (lo_q < size_q) ? S_INS_CHK : S_INS_NEW;
            K_LOC:   state_d = S_LK_RD;
            default: state_d = S_WK_RD;
          endcase
        end
      end
      S_SRCH_CMP: state_d = S_SRCH;
      S_INS_CHK:  state_d = (rd_point == vh_q) ? S_VADV : S_INS_NEW;
      S_INS_NEW:  state_d = (size_q >= SizeW'(RingDepth)) ? S_VADV : S_SHIFT_RD;
      S_SHIFT_RD: state_d = (j_q > lo_q) ? S_SHIFT_WR : S_VADV;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_VADV:     state_d = (v_q == VnW'(Vnodes - 1)) ? S_RB_SLOT : S_VH_SHARP;
      S_LK_RD:    state_d = S_IDLE;
      S_WK_RD:    state_d = walk_go ? S_WK_EV : S_IDLE;
      S_WK_EV:    state_d = S_WK_RD;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath, memory and result control.
  always_comb begin
    kind_d = kind_q;  rh_d = rh_q;  vh_d = vh_q;  size_d = size_q;
    lo_d = lo_q;  hi_d = hi_q;  mid_d = mid_q;  j_d = j_q;  vis_d = vis_q;
    s_d = s_q;  v_d = v_q;  idx_d = idx_q;  want_d = want_q;  n_d = n_q;
    seen_d = seen_q;  pend_v_d = pend_v_q;  pend_d = pend_q;
    ov_d = 1'b0;  oo_d = '0;  of_d = 1'b0;  ol_d = 1'b0;
    swr = '0;
    swr.slot  = node_slot_i[SlotW-1:0];
    swr.alive = start_alive_i;
    swr.hash  = fh;
    ram_we = 1'b0;  ram_waddr = lo_q[RingAw-1:0];
    ram_wdata = {vh_q, cur_slot};  ram_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          s_d = '0;  v_d = '0;
          case (opcode_i)
            OP_ADD: begin
              rh_d = last_byte_i ? FnvBasis : fh;
              if (last_byte_i && slot_ok) begin
                swr.we_used = 1'b1;  swr.used = 1'b1;
                swr.we_alive = 1'b1;  swr.we_hash = 1'b1;
                size_d = '0;
              end
            end
            OP_REMOVE: begin
              if (slot_ok) begin
                swr.we_used = 1'b1;  swr.we_alive = 1'b1;  swr.alive = 1'b0;
                size_d = '0;
              end
            end
            OP_DOWN, OP_UP: begin
              if (slot_ok && used[node_slot_i]) begin
                swr.we_alive = 1'b1;  swr.alive = (opcode_i == OP_UP);
                size_d = '0;
              end
            end
            OP_LOCATE, OP_REPLICAS: begin
              rh_d = last_byte_i ? FnvBasis : fh;
              if (key_end) begin
                if (empty_res) begin
                  ov_d = 1'b1;  ol_d = 1'b1;
                end else begin
                  vh_d = fh;  lo_d = '0;  hi_d = size_q;
                  kind_d = (opcode_i == OP_LOCATE) ? K_LOC : K_REP;
                  want_d = (replica_count_i > 5'(WantLim)) ? 5'(WantLim) : replica_count_i;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RB_SLOT: begin
        if (s_q != (SlotW+1)'(NodeSlots) && !(used[cur_slot] && alive[cur_slot])) begin
          s_d = s_q + 1'b1;
        end
      end
      S_VH_SHARP: vh_d = fold(slot_hash, CharHash);
      S_VH_TENS:  vh_d = fold(vh_q, CharZero + tens);
      S_VH_ONES: begin
        vh_d = fold(vh_q, CharZero + ones);
        lo_d = '0;  hi_d = size_q;  kind_d = K_INS;
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d = mid;
          ram_raddr = mid[RingAw-1:0];
        end else begin
          case (kind_q)
            K_INS: ram_raddr = lo_q[RingAw-1:0];
            default: begin
              // Past the last point the lookup wraps to the first one.
              idx_d = (lo_q < size_q) ? lo_q[RingAw-1:0] : '0;
              ram_raddr = idx_d;
              vis_d = '0;  n_d = '0;  seen_d = '0;  pend_v_d = 1'b0;
            end
          endcase
        end
      end
      S_SRCH_CMP: begin
        if (rd_point < vh_q) lo_d = mid_q + 1'b1;
        else hi_d = mid_q;
      end
      S_INS_CHK: begin
        // An equal point keeps one entry; slots arrive in ascending order.
        if (rd_point == vh_q) ram_we = 1'b1;
      end
      S_INS_NEW:  j_d = size_q;
      S_SHIFT_RD: begin
        if (j_q > lo_q) begin
          ram_raddr = RingAw'(j_q - 1'b1);
        end else begin
          ram_we = 1'b1;
          size_d = size_q + 1'b1;
        end
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
        ram_waddr = j_q[RingAw-1:0];
        ram_wdata = ram_rdata;
        j_d = j_q - 1'b1;
      end
      S_VADV: begin
        if (v_q == VnW'(Vnodes - 1)) begin
          v_d = '0;  s_d = s_q + 1'b1;
        end else begin
          v_d = v_q + 1'b1;
        end
      end
      S_LK_RD: begin
        ov_d = 1'b1;  oo_d = rd_owner;  of_d = 1'b1;  ol_d = 1'b1;
      end
      S_WK_RD: begin
        if (walk_go) begin
          ram_raddr = idx_q;
        end else begin
          ov_d = 1'b1;  oo_d = pend_q;  of_d = 1'b1;  ol_d = 1'b1;
        end
      end
      S_WK_EV: begin
        vis_d = vis_q + 1'b1;
        idx_d = (idx_inc >= size_q) ? '0 : idx_inc[RingAw-1:0];
        // Each owner is held back one step so that the final one can be flagged.
        if (!seen_q[rd_owner]) begin
          seen_d[rd_owner] = 1'b1;
          n_d = n_q + 1'b1;
          if (pend_v_q) begin
            ov_d = 1'b1;  oo_d = pend_q;  of_d = 1'b1;
          end
          pend_d = rd_owner;
          pend_v_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= K_INS;
      rh_q     <= FnvBasis;
      size_q   <= '0;
      s_q      <= '0;
      v_q      <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      rh_q     <= rh_d;
      size_q   <= size_d;
      s_q      <= s_d;
      v_q      <= v_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vh_q   <= vh_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    j_q    <= j_d;
    vis_q  <= vis_d;
    idx_q  <= idx_d;
    want_q <= want_d;
    n_q    <= n_d;
    seen_q <= seen_d;
    pend_q <= pend_d;
    oo_q   <= oo_d;
    of_q   <= of_d;
    ol_q   <= ol_d;
  end

  assign result_valid_o = ov_q;
  assign owner_slot_o   = oo_q;
  assign found_o        = of_q;
  assign last_result_o  = ol_q;

endmodule
